### rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro takes a label, clock, active-low reset, antecedent and consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/s2d_pkg.sv
// ----------------------------------------------------------------------------
// s2d_pkg
// Constants, types and state encoding for the signed binary to decimal
// ASCII converter.
// ----------------------------------------------------------------------------
package s2d_pkg;

	// Converted width; the input field stays 64 bits, only the low bits are used.
	localparam int VALUE_WIDTH = 64;
	localparam int IN_W        = 64;
	localparam int CHAR_W      = 7;

	// Decimal digits of 2^(VALUE_WIDTH-1): floor((W-1)*log10(2)) + 1.
	localparam int STORE_DEPTH = (((VALUE_WIDTH - 1) * 1233) >> 12) + 1;
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int IDX_W       = $clog2(STORE_DEPTH);

	// Divider retires DIV_BITS quotient bits per cycle.
	localparam int DIV_BITS  = 8;
	localparam int DIV_STEPS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
	localparam int PAD_W     = DIV_STEPS * DIV_BITS;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);

	localparam logic [4:0]        DIV_TEN    = 5'd10;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

	typedef struct packed {
		logic             start;
		logic [PAD_W-1:0] operand;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [PAD_W-1:0] quotient;
		logic [3:0]       remainder;
	} div_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_EMIT
	} s2d_state_t;

endpackage

### rtl/s2d_stream_if.sv
// ----------------------------------------------------------------------------
// s2d_num_if / s2d_char_if
// Valid/ready channels: the integer in, one ASCII character per transfer out.
// ----------------------------------------------------------------------------
interface s2d_num_if import s2d_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [IN_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface s2d_char_if import s2d_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              last;

	modport source (output valid, output char_code, output last, input ready);
	modport sink   (input valid, input char_code, input last, output ready);
endinterface

### rtl/s2d_div10.sv
// ----------------------------------------------------------------------------
// s2d_div10
// Iterative restoring divide by ten, DIV_BITS quotient bits per cycle.
// ----------------------------------------------------------------------------
module s2d_div10 import s2d_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [PAD_W-1:0]  dvd_q;
	logic [3:0]        rem_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [PAD_W-1:0] dvd_next;
	logic [3:0]       rem_next;

	// Quotient bits shift into the low end as dividend bits leave the top.
	always_comb begin
		logic [4:0] part;
		dvd_next = dvd_q;
		rem_next = rem_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			part     = {rem_next, dvd_next[PAD_W-1]};
			dvd_next = {dvd_next[PAD_W-2:0], 1'b0};
			if (part >= DIV_TEN) begin
				part        = part - DIV_TEN;
				dvd_next[0] = 1'b1;
			end
			rem_next = part[3:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == STEP_W'(DIV_STEPS - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.operand;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_next;
			rem_q <= rem_next;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = dvd_q;
	assign rsp.remainder = rem_q;

endmodule

### rtl/signed_binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Converts a two's complement integer to its decimal ASCII text.
// ----------------------------------------------------------------------------
// Usage:
//   number : valid/ready input, one signed integer per transfer (low
//            VALUE_WIDTH bits used, top one of those is the sign).
//   text   : valid/ready output, one ASCII character per transfer, most
//            significant first; '-' leads a negative value, last marks the
//            final digit. Zero gives a single '0'.
//   Timing : number.ready is high only while idle. A value with D decimal
//            digits makes D passes through the divide-by-ten unit
//            (DIV_STEPS = 8 at 64 bits: one step per quotient byte), then
//            emits one character per cycle when text is not stalled, then
//            returns to idle.
//   Reset  : arst_n clears the sequencer and the output valid flag; no
//            character is pending afterward.
//   Stall  : a character waits in the output register while text.ready is
//            low; conversion pauses, nothing is dropped. The last character
//            may still wait there while the next number is taken.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii import s2d_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	s2d_num_if.sink      number,
	s2d_char_if.source   text
);

	s2d_state_t state_q, state_d;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// Digit store, least significant digit first.
	logic [3:0]        store_q [STORE_DEPTH];
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  idx_q;
	logic              sign_q;      // '-' still to be sent

	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_last_q;

	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] magnitude;
	logic                   negative;
	logic                   accept;
	logic                   quot_zero;
	logic                   out_load;
	logic [CHAR_W-1:0]      char_next;
	logic                   last_next;

	// Magnitude taken unsigned, so the most negative value comes out exact.
	assign raw       = number.value[VALUE_WIDTH-1:0];
	assign negative  = raw[VALUE_WIDTH-1];
	assign magnitude = negative ? (~raw + 1'b1) : raw;
	assign accept    = number.valid && number.ready;
	assign quot_zero = (div_rsp.quotient == '0);

	s2d_div10 u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (number.valid) state_d = ST_DIVIDE;
			ST_DIVIDE: if (div_rsp.done && quot_zero) state_d = ST_EMIT;
			ST_EMIT:   if (out_load && last_next) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		number.ready    = 1'b0;
		div_req.start   = 1'b0;
		div_req.operand = div_rsp.quotient;
		out_load        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				number.ready    = 1'b1;
				div_req.start   = number.valid;
				div_req.operand = PAD_W'(magnitude);
			end
			ST_DIVIDE: begin
				// keep dividing until the quotient runs out (at least once)
				div_req.start = div_rsp.done && !quot_zero;
			end
			ST_EMIT: begin
				out_load = !out_valid_q || text.ready;
			end
			default: ;
		endcase
	end

	// Next character: sign first, then digits from the top of the store.
	assign char_next = sign_q ? CHAR_MINUS : (CHAR_ZERO + CHAR_W'(store_q[idx_q]));
	assign last_next = !sign_q && (idx_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			sign_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				count_q <= '0;
				sign_q  <= negative;
			end
			if (state_q == ST_DIVIDE && div_rsp.done) begin
				if (count_q < CNT_W'(STORE_DEPTH))
					count_q <= count_q + 1'b1;
				if (quot_zero)
					idx_q <= count_q[IDX_W-1:0];   // index of the top digit
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (sign_q)
					sign_q <= 1'b0;
				else
					idx_q <= idx_q - 1'b1;
			end else if (text.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload, no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_DIVIDE && div_rsp.done && count_q < CNT_W'(STORE_DEPTH))
			store_q[count_q[IDX_W-1:0]] <= div_rsp.remainder;
		if (out_load) begin
			out_char_q <= char_next;
			out_last_q <= last_next;
		end
	end

	assign text.valid     = out_valid_q;
	assign text.char_code = out_char_q;
	assign text.last      = out_last_q;

endmodule

### rtl/s2d_checker.sv
// ----------------------------------------------------------------------------
// s2d_checker
// Port-level checks on the converter, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module s2d_checker import s2d_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CHAR_W-1:0] out_char,
	input logic              out_last
);

	// one number at a time: busy right after a transfer in
	`ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_valid && in_ready, !in_ready)

	// stalled character holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(out_last))

	// only '-' or a decimal digit leaves the block
	`ASSERT_IMPLY(a_char_set, clk, arst_n, out_valid, (out_char == CHAR_MINUS) || ((out_char >= CHAR_ZERO) && (out_char <= CHAR_ZERO + 7'd9)))

	// a sign is never the final character
	`ASSERT_IMPLY(a_sign_not_last, clk, arst_n, out_valid && (out_char == CHAR_MINUS), !out_last)

endmodule

bind signed_binary_to_decimal_ascii s2d_checker u_s2d_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (number.valid),
	.in_ready  (number.ready),
	.out_valid (text.valid),
	.out_ready (text.ready),
	.out_char  (text.char_code),
	.out_last  (text.last)
);
